### rtl/lnf_pkg.sv
`timescale 1ns / 1ps
// Package for the layer normalisation forward unit.
// Holds sizes, register indexes and reset values; depends on nothing.
package lnf_pkg;

  localparam int MaxFeatures = 64;
  localparam int AddrW       = $clog2(MaxFeatures);
  localparam int CountW      = AddrW + 1;

  localparam int DataW       = 16;
  localparam int EpsW        = 24;
  localparam int InvW        = 24;
  localparam int CfgDataW    = 24;
  localparam int SumW        = 22;
  localparam int SqAccW      = 38;
  localparam int DivNumW     = 49;
  localparam int DivDenW     = 33;

  // Configuration register indexes.
  localparam logic CfgFeatureCount = 1'b0;
  localparam logic CfgEpsilonValue = 1'b1;

  localparam logic [CountW-1:0] FeatureCountReset = CountW'(MaxFeatures);
  localparam logic [EpsW-1:0]   EpsilonReset      = EpsW'(66);

  // One stored element: x, scale and offset side by side.
  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] scale;
    logic signed [DataW-1:0] offset;
  } elem_t;

endpackage

### rtl/layer_norm_forward_unit.sv
`timescale 1ns / 1ps
// Layer normalisation forward unit: buffers a row, then emits normalised words.
// Depends on lnf_pkg and lnf_ram.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------------
//  input     | in        | start_i, taken when !busy | x_value_i, scale_value_i, offset_value_i
//  result    | out       | valid_o, one cycle each   | y_value_o, row_mean_o, row_inv_std_o,
//            |           |                           | last_of_row_o
//  config    | in        | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// Elements of a row are taken one a cycle while busy is low. The word that closes
// a row raises busy through the mean and variance divisions, the 2^48/t division
// with its set-up step, the bit-serial inverse square root, and the two
// streaming passes over the element RAM (the 2^48/t division and the root are
// skipped when variance plus epsilon is zero).
// Results leave one a cycle and cannot be stalled. Reset leaves an empty row.
module layer_norm_forward_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [lnf_pkg::DataW-1:0] x_value_i,
  input  logic signed [lnf_pkg::DataW-1:0] scale_value_i,
  input  logic signed [lnf_pkg::DataW-1:0] offset_value_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [lnf_pkg::CfgDataW-1:0]    cfg_data_i,
  output logic                            valid_o,
  output logic signed [lnf_pkg::DataW-1:0] y_value_o,
  output logic signed [lnf_pkg::DataW-1:0] row_mean_o,
  output logic [lnf_pkg::InvW-1:0]        row_inv_std_o,
  output logic                            last_of_row_o
);
  import lnf_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMdiv = 3'd1;
  localparam logic [2:0] StVar  = 3'd2;
  localparam logic [2:0] StVdiv = 3'd3;
  localparam logic [2:0] StLdiv = 3'd4;
  localparam logic [2:0] StIsqM = 3'd5;
  localparam logic [2:0] StIsqC = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  localparam logic [5:0] DivSteps = 6'(DivNumW - 1);

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [CountW-1:0] fc_q;
  logic [EpsW-1:0]   eps_q;
  logic [CountW-1:0] d_eff;

  // Row accumulation.
  logic [CountW-1:0]      count_q, count_d, n_q, n_d;
  logic signed [SumW-1:0] sum_q, sum_d, sum_new;
  logic                   accept, closes;

  // Shared divider.
  logic [DivNumW-1:0] div_num_q, div_num_d;
  logic [DivDenW-1:0] div_den_q, div_den_d;
  logic [DivDenW-1:0] div_rem_q, div_rem_d;
  logic [5:0]         div_cnt_q, div_cnt_d;
  logic               neg_q, neg_d;
  logic [DivDenW:0]   rem_sh, rem_sub;
  logic               rem_ge;
  logic [DivNumW-1:0] div_num_step;
  logic [DivDenW-1:0] div_rem_step;

  // Row results.
  logic signed [DataW-1:0] mean_q, mean_d;
  logic [InvW-1:0]         inv_q, inv_d;
  logic [DivNumW-1:0]      limit_q, limit_d;
  logic [DivDenW-1:0]      t_val;
  logic [4:0]              bit_q, bit_d;
  logic [InvW-1:0]         cand_q, cand_d;
  logic [2*InvW-1:0]       csq_q, csq_d;
  logic [SqAccW-1:0]       sq_acc_q, sq_acc_d;

  // Streaming read pipeline.
  logic [CountW-1:0] rd_idx_q, rd_idx_d;
  logic              issue;
  logic              s0_v_q, s0_last_q;
  logic              a_v_q, a_last_q;
  logic              b_v_q, b_last_q;
  logic              c_v_q, c_last_q;
  logic              pipe_busy;

  logic signed [DataW:0]      a_c_q;
  logic signed [DataW-1:0]    a_scale_q, a_off_q, b_scale_q, b_off_q;
  logic [2*DataW-1:0]         b_sq_q;
  logic signed [DataW+InvW+1:0] b_p1_q;
  logic signed [57:0]         c_p2_q;
  logic signed [29:0]         y_full;

  logic              valid_q;
  logic signed [DataW-1:0] y_q;
  logic              last_q;

  elem_t wr_elem, rd_elem;

  // Element RAM: written only while idle, read only while busy, so no overlap.
  assign wr_elem = '{x: x_value_i, scale: scale_value_i, offset: offset_value_i};

  lnf_ram #(
    .Width($bits(elem_t)),
    .Depth(MaxFeatures)
  ) u_elem_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(wr_elem),
    .raddr_i(rd_idx_q[AddrW-1:0]),
    .rdata_o(rd_elem)
  );

  // Effective row length, clamped to one and the store depth.
  always_comb begin
    if (fc_q == '0) begin
      d_eff = CountW'(1);
    end else if (fc_q > CountW'(MaxFeatures)) begin
      d_eff = CountW'(MaxFeatures);
    end else begin
      d_eff = fc_q;
    end
  end

  assign busy_o  = (state_q != StIdle);
  assign accept  = start_i && !busy_o;
  assign sum_new = sum_q + SumW'(x_value_i);
  assign closes  = (count_q + CountW'(1)) >= d_eff;

  // One restoring division step.
  assign rem_sh       = {div_rem_q, div_num_q[DivNumW-1]};
  assign rem_ge       = rem_sh >= {1'b0, div_den_q};
  assign rem_sub      = rem_sh - {1'b0, div_den_q};
  assign div_rem_step = rem_ge ? rem_sub[DivDenW-1:0] : rem_sh[DivDenW-1:0];
  assign div_num_step = {div_num_q[DivNumW-2:0], rem_ge};

  assign t_val     = {1'b0, div_num_q[31:0]} + DivDenW'(eps_q);
  assign issue     = ((state_q == StVar) || (state_q == StOut)) && (rd_idx_q < n_q);
  assign pipe_busy = s0_v_q || a_v_q || b_v_q || c_v_q;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    n_d       = n_q;
    sum_d     = sum_q;
    div_num_d = div_num_q;
    div_den_d = div_den_q;
    div_rem_d = div_rem_q;
    div_cnt_d = div_cnt_q;
    neg_d     = neg_q;
    mean_d    = mean_q;
    inv_d     = inv_q;
    limit_d   = limit_q;
    bit_d     = bit_q;
    cand_d    = cand_q;
    csq_d     = csq_q;
    sq_acc_d  = sq_acc_q;
    rd_idx_d  = issue ? rd_idx_q + CountW'(1) : rd_idx_q;

    if ((state_q == StVar) && b_v_q) begin
      sq_acc_d = sq_acc_q + SqAccW'(b_sq_q);
    end

    if ((state_q == StMdiv) || (state_q == StVdiv) || (state_q == StLdiv)) begin
      div_num_d = div_num_step;
      div_rem_d = div_rem_step;
      div_cnt_d = div_cnt_q - 6'd1;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (closes) begin
            n_d       = count_q + CountW'(1);
            neg_d     = sum_new[SumW-1];
            div_num_d = DivNumW'(neg_d ? -sum_new : sum_new);
            div_den_d = DivDenW'(count_q + CountW'(1));
            div_rem_d = '0;
            div_cnt_d = DivSteps;
            count_d   = '0;
            sum_d     = '0;
            state_d   = StMdiv;
          end else begin
            count_d = count_q + CountW'(1);
            sum_d   = sum_new;
          end
        end
      end
      StMdiv: begin
        if (div_cnt_q == '0) begin
          // Floor of a negative quotient rounds the magnitude up.
          if (neg_q) begin
            mean_d = -DataW'(div_num_step + DivNumW'(div_rem_step != '0));
          end else begin
            mean_d = DataW'(div_num_step);
          end
          rd_idx_d = '0;
          sq_acc_d = '0;
          state_d  = StVar;
        end
      end
      StVar: begin
        if (!issue && !pipe_busy) begin
          div_num_d = DivNumW'(sq_acc_q);
          div_den_d = DivDenW'(n_q);
          div_rem_d = '0;
          div_cnt_d = DivSteps;
          state_d   = StVdiv;
        end
      end
      StVdiv: begin
        if (div_cnt_q == '0) begin
          // Quotient is the variance; add epsilon for the inverse root.
          div_num_d = div_num_step;
          state_d   = StLdiv;
        end
      end
      StLdiv: begin
        // First cycle here: the variance sits in the numerator register.
        if (div_cnt_q == DivSteps && div_den_q == '1) begin
          div_den_d = '1;
          if (t_val == '0) begin
            inv_d    = '1;
            rd_idx_d = '0;
            state_d  = StOut;
          end else begin
            div_num_d = DivNumW'(1) << 48;
            div_den_d = t_val;
            div_rem_d = '0;
            div_cnt_d = DivSteps;
          end
        end else if (div_cnt_q == '0) begin
          limit_d = div_num_step;
          inv_d   = '0;
          bit_d   = 5'(InvW - 1);
          state_d = StIsqM;
        end
      end
      StIsqM: begin
        cand_d  = inv_q | (InvW'(1) << bit_q);
        csq_d   = (2*InvW)'(cand_d) * (2*InvW)'(cand_d);
        state_d = StIsqC;
      end
      StIsqC: begin
        if ({1'b0, csq_q} <= limit_q) begin
          inv_d = cand_q;
        end
        if (bit_q == '0) begin
          rd_idx_d = '0;
          state_d  = StOut;
        end else begin
          bit_d   = bit_q - 5'd1;
          state_d = StIsqM;
        end
      end
      StOut: begin
        if (!issue && !pipe_busy) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // The variance division ends by loading a marker divisor so the
  // following state can tell its first cycle apart.
  logic [DivDenW-1:0] den_mark;
  assign den_mark = ((state_q == StVdiv) && (div_cnt_q == '0)) ? '1 : div_den_d;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fc_q      <= FeatureCountReset;
      eps_q     <= EpsilonReset;
      count_q   <= '0;
      sum_q     <= '0;
      rd_idx_q  <= '0;
      div_cnt_q <= '0;
      s0_v_q    <= 1'b0;
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      c_v_q     <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      rd_idx_q  <= rd_idx_d;
      div_cnt_q <= (state_d == StLdiv && state_q == StVdiv) ? DivSteps : div_cnt_d;
      s0_v_q    <= issue;
      a_v_q     <= s0_v_q;
      b_v_q     <= a_v_q;
      c_v_q     <= b_v_q && (state_q == StOut);
      valid_q   <= c_v_q;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgFeatureCount: fc_q  <= cfg_data_i[CountW-1:0];
          CfgEpsilonValue: eps_q <= cfg_data_i[EpsW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    div_num_q <= div_num_d;
    div_den_q <= den_mark;
    div_rem_q <= div_rem_d;
    neg_q     <= neg_d;
    mean_q    <= mean_d;
    inv_q     <= inv_d;
    limit_q   <= limit_d;
    bit_q     <= bit_d;
    cand_q    <= cand_d;
    csq_q     <= csq_d;
    sq_acc_q  <= sq_acc_d;
    s0_last_q <= (rd_idx_q + CountW'(1)) == n_q;
    // Stage A: centre the element.
    a_c_q     <= (DataW+1)'(rd_elem.x) - (DataW+1)'(mean_q);
    a_scale_q <= rd_elem.scale;
    a_off_q   <= rd_elem.offset;
    a_last_q  <= s0_last_q;
    // Stage B: square for the variance, or times the inverse root.
    b_sq_q    <= (2*DataW)'(a_c_q * a_c_q);
    b_p1_q    <= a_c_q * $signed({1'b0, inv_q});
    b_scale_q <= a_scale_q;
    b_off_q   <= a_off_q;
    b_last_q  <= a_last_q;
    // Stage C: times the scale plus the offset aligned to Q.36.
    c_p2_q    <= 58'(b_p1_q) * 58'(b_scale_q) + (58'(b_off_q) <<< 24);
    c_last_q  <= b_last_q;
    // Output stage: floor to Q8.8 and saturate.
    if (y_full > 30'sd32767) begin
      y_q <= 16'sh7FFF;
    end else if (y_full < -30'sd32768) begin
      y_q <= -16'sh8000;
    end else begin
      y_q <= y_full[DataW-1:0];
    end
    last_q <= c_last_q;
  end

  assign y_full = c_p2_q[57:28];

  assign valid_o       = valid_q;
  assign y_value_o     = y_q;
  assign row_mean_o    = mean_q;
  assign row_inv_std_o = inv_q;
  assign last_of_row_o = last_q;

endmodule

### rtl/lnf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read.
// Self-contained; used by the layer normalisation forward unit.
module lnf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read-first: a read of the address being written returns the old word; read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/layer_norm_forward_checker.sv
`timescale 1ns / 1ps
// Checker for the layer normalisation forward unit: predicts each row's words.
// Depends on lnf_pkg; watches the input, config and result ports of the block.
module layer_norm_forward_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic signed [lnf_pkg::DataW-1:0] x_value_i,
  input  logic signed [lnf_pkg::DataW-1:0] scale_value_i,
  input  logic signed [lnf_pkg::DataW-1:0] offset_value_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [lnf_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             valid_i,
  input  logic signed [lnf_pkg::DataW-1:0] y_value_i,
  input  logic signed [lnf_pkg::DataW-1:0] row_mean_i,
  input  logic [lnf_pkg::InvW-1:0]         row_inv_std_i,
  input  logic                             last_of_row_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import lnf_pkg::*;

  typedef struct {
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] mean;
    logic [InvW-1:0]         inv_std;
    logic                    last;
  } norm_word_t;

  norm_word_t expected_words[$];

  // Model copy of the row buffer, running sum and registers.
  logic signed [DataW-1:0] row_x[MaxFeatures];
  logic signed [DataW-1:0] row_scale[MaxFeatures];
  logic signed [DataW-1:0] row_offset[MaxFeatures];
  int                      row_fill;
  longint                  row_sum;
  logic [CountW-1:0]       model_features;
  logic [EpsW-1:0]         model_epsilon;

  assign pending_o = expected_words.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Largest unsigned Q8.16 v with v*v*t <= 2^48, saturated for t of zero.
  function automatic logic [InvW-1:0] inverse_root(input longint unsigned t);
    longint unsigned bound, v, c;
    v = 0;
    if (t == 0) return '1;
    bound = (64'd1 << 48) / t;
    for (int b = InvW - 1; b >= 0; b--) begin
      c = v | (64'd1 << b);
      if (c * c <= bound) v = c;
    end
    return v[InvW-1:0];
  endfunction

  // A row has closed: work out mean, inverse deviation and every word.
  task automatic close_row();
    longint mean, c, acc, y;
    longint unsigned sq, variance;
    logic [InvW-1:0] inv;
    norm_word_t w;
    mean = row_sum / row_fill;
    if ((row_sum % row_fill) != 0 && row_sum < 0) mean--;
    sq = 0;
    for (int i = 0; i < row_fill; i++) begin
      c = longint'(row_x[i]) - mean;
      sq += longint'(c * c);
    end
    variance = sq / row_fill;
    inv = inverse_root(variance + model_epsilon);
    for (int i = 0; i < row_fill; i++) begin
      c = longint'(row_x[i]) - mean;
      acc = c * longint'({1'b0, inv}) * longint'(row_scale[i]);
      acc += longint'(row_offset[i]) * (64'sd1 <<< 24);
      y = acc >>> 28;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      w.y       = y[DataW-1:0];
      w.mean    = mean[DataW-1:0];
      w.inv_std = inv;
      w.last    = (i + 1 == row_fill);
      expected_words.push_back(w);
    end
    row_fill = 0;
    row_sum  = 0;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_fill       = 0;
      row_sum        = 0;
      model_features = FeatureCountReset;
      model_epsilon  = EpsilonReset;
      expected_words.delete();
    end else begin
      // Compare each result word with the oldest prediction.
      if (valid_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected", $realtime);
          fail_count_o++;
        end else begin
          norm_word_t w;
          w = expected_words.pop_front();
          if (y_value_i !== w.y) report_mismatch("y_value", y_value_i, w.y);
          if (row_mean_i !== w.mean) report_mismatch("row_mean", row_mean_i, w.mean);
          if (row_inv_std_i !== w.inv_std)
            report_mismatch("row_inv_std", row_inv_std_i, w.inv_std);
          if (last_of_row_i !== w.last) report_mismatch("last_of_row", last_of_row_i, w.last);
        end
      end
      // Register writes.
      if (cfg_we_i) begin
        if (cfg_index_i == CfgFeatureCount) model_features = cfg_data_i[CountW-1:0];
        else model_epsilon = cfg_data_i[EpsW-1:0];
      end
      // An accepted element: buffer it and close the row when it is full.
      if (start_i && !busy_i) begin
        int d_eff, slot;
        d_eff = model_features;
        if (d_eff < 1) d_eff = 1;
        if (d_eff > MaxFeatures) d_eff = MaxFeatures;
        slot = (row_fill >= MaxFeatures) ? MaxFeatures - 1 : row_fill;
        row_x[slot]      = x_value_i;
        row_scale[slot]  = scale_value_i;
        row_offset[slot] = offset_value_i;
        row_sum += longint'(x_value_i);
        row_fill = slot + 1;
        if (row_fill >= d_eff) close_row();
      end
    end
  end

endmodule

### tb/layer_norm_forward_unit_test.sv
`timescale 1ns / 1ps
// Top of the layer normalisation testbench: clock, reset, stimulus and verdict.
// Depends on lnf_pkg, layer_norm_forward_unit and layer_norm_forward_checker.
module layer_norm_forward_unit_test;
  import lnf_pkg::*;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic signed [DataW-1:0] x_value_i = '0;
  logic signed [DataW-1:0] scale_value_i = '0;
  logic signed [DataW-1:0] offset_value_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic                    cfg_index_i = CfgFeatureCount;
  logic [CfgDataW-1:0]     cfg_data_i = '0;
  logic                    valid_o;
  logic signed [DataW-1:0] y_value_o;
  logic signed [DataW-1:0] row_mean_o;
  logic [InvW-1:0]         row_inv_std_o;
  logic                    last_of_row_o;
  int                      fail_count;
  int                      pending;
  int                      words_sent;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  layer_norm_forward_unit dut (.*);

  layer_norm_forward_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .x_value_i, .scale_value_i,
    .offset_value_i, .cfg_we_i, .cfg_index_i, .cfg_data_i, .valid_i(valid_o),
    .y_value_i(y_value_o), .row_mean_i(row_mean_o), .row_inv_std_i(row_inv_std_o),
    .last_of_row_i(last_of_row_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Present one element and hold it until the block takes it.
  task automatic send_word(input logic [15:0] x, input logic [15:0] s, input logic [15:0] o);
    @(negedge clk_i);
    start_i        = 1'b1;
    x_value_i      = x;
    scale_value_i  = s;
    offset_value_i = o;
    do @(posedge clk_i); while (busy_o);
    words_sent++;
  endtask

  task automatic idle_for(input int cycles);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Wait until every predicted word is out and the block is quiet.
  task automatic drain();
    idle_for(0);
    while (pending != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic write_reg(input logic index, input logic [CfgDataW-1:0] data);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  function automatic logic [15:0] pick_x(input logic [15:0] centre);
    if ($urandom_range(1, 0) == 1) return $urandom;
    return centre + 16'($urandom_range(1023)) - 16'd512;
  endfunction

  initial begin
    int burst, d, max_d;
    logic [15:0] centre;
    words_sent = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Extremes of every field on a row of four.
    write_reg(CfgFeatureCount, 4);
    write_reg(CfgEpsilonValue, 0);
    send_word(16'h8000, 16'h7FFF, 16'h8000);
    send_word(16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(16'h0000, 16'hFFFF, 16'h0000);
    send_word(16'hFFFF, 16'h0001, 16'hFFFF);
    // Flat row with no epsilon: inverse deviation saturates.
    repeat (4) send_word(16'h0123, 16'h1000, 16'h0100);
    // Largest epsilon.
    write_reg(CfgEpsilonValue, 24'hFFFFFF);
    repeat (4) send_word(pick_x(0), $urandom, $urandom);
    // Zero length acts as one; lengths above the limit act as the limit.
    write_reg(CfgFeatureCount, 0);
    send_word(16'h0400, 16'h1000, 16'h0000);
    send_word(16'hFC00, 16'h1000, 16'h0000);
    write_reg(CfgEpsilonValue, 66);
    // Row length lowered mid-row: the next element closes the row.
    write_reg(CfgFeatureCount, 64);
    repeat (3) send_word(pick_x(16'h0200), $urandom, $urandom);
    write_reg(CfgFeatureCount, 2);
    send_word(pick_x(16'h0200), $urandom, $urandom);
    write_reg(CfgFeatureCount, 127);
    repeat (64) send_word($urandom, $urandom, $urandom);
    drain();

    // Random phases, mostly short rows; a long row is left open for a later phase.
    while (words_sent < 120) begin
      case ($urandom_range(7))
        0:       d = 1;
        1:       d = 64;
        2:       d = $urandom_range(127, 65);
        default: d = $urandom_range(8, 2);
      endcase
      write_reg(CfgFeatureCount, CfgDataW'(d));
      write_reg(CfgEpsilonValue, ($urandom_range(3) == 0) ? $urandom : $urandom_range(4096));
      max_d  = (d > 8) ? 1 : 3;
      centre = $urandom;
      for (int r = 0; r < max_d * ((d > 8) ? 16 : d) + $urandom_range(2); r++) begin
        send_word(pick_x(centre), $urandom, $urandom);
        if ($urandom_range(3) == 0) begin
          burst = $urandom_range(5);
          idle_for(burst);
        end
      end
      // With 91 to 109 words sent, sit still until every expected word is back.
      if (words_sent > 90 && words_sent < 110) drain();
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
